// ===== rtl/scd_pkg.sv =====
// scd_pkg: shared types, character codes and action codes of the serial command decoder
// no dependencies; imported by the decoder core and the top level
`timescale 1ns / 1ps

package scd_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned ActionWidth = 5;
   localparam int unsigned ChanWidth   = 3;
   localparam int unsigned ValueWidth  = 16;
   localparam int unsigned RspWidth    = ActionWidth + ByteWidth + ChanWidth + ValueWidth;

   localparam logic [ValueWidth-1:0] RelayPulseReset = 16'd2000;

   // character codes
   localparam logic [7:0] ChSlash  = 8'h2F;
   localparam logic [7:0] ChDot    = 8'h2E;
   localparam logic [7:0] ChLbrace = 8'h7B;
   localparam logic [7:0] ChRbrace = 8'h7D;
   localparam logic [7:0] ChP      = 8'h70;
   localparam logic [7:0] ChF      = 8'h66;
   localparam logic [7:0] ChA      = 8'h61;
   localparam logic [7:0] ChD      = 8'h64;
   localparam logic [7:0] ChM      = 8'h6D;
   localparam logic [7:0] ChN      = 8'h6E;
   localparam logic [7:0] ChR      = 8'h72;
   localparam logic [7:0] ChS      = 8'h73;
   localparam logic [7:0] ChT      = 8'h74;
   localparam logic [7:0] ChU      = 8'h75;
   localparam logic [7:0] Ch0      = 8'h30;
   localparam logic [7:0] Ch1      = 8'h31;
   localparam logic [7:0] Ch2      = 8'h32;
   localparam logic [7:0] Ch3      = 8'h33;
   localparam logic [7:0] Ch9      = 8'h39;

   typedef enum logic [ActionWidth-1:0] {
      ACT_NONE        = 5'd0,
      ACT_PASS        = 5'd1,
      ACT_ECHO_SLASH  = 5'd2,
      ACT_RADIO_MODE  = 5'd3,
      ACT_RADIO_TOG   = 5'd4,
      ACT_RADIO_REG   = 5'd5,
      ACT_TX_BUF      = 5'd6,
      ACT_TX_ADDR     = 5'd7,
      ACT_RELAY_PULSE = 5'd8,
      ACT_RELAY_A_OFF = 5'd9,
      ACT_RELAY_A_ON  = 5'd10,
      ACT_RELAY_B_OFF = 5'd11,
      ACT_RELAY_B_ON  = 5'd12,
      ACT_MSG_OPEN    = 5'd13,
      ACT_MSG_ECHO    = 5'd14,
      ACT_MSG_ABORT   = 5'd15,
      ACT_SET_PWM     = 5'd16,
      ACT_SET_PERIOD  = 5'd17,
      ACT_ACCEL       = 5'd18,
      ACT_EMPTY_CLOSE = 5'd19
   } action_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_ACCEL  = 2'd1,
      KIND_PERIOD = 2'd2,
      KIND_PWM    = 2'd3
   } kind_type;

   typedef struct packed {
      logic                  cmd_mode;
      logic                  in_msg;
      kind_type              kind;
      logic [ValueWidth-1:0] width_acc;
      logic [ValueWidth-1:0] period_acc;
      logic [ChanWidth-1:0]  chan;
   } state_type;

   // packed lowest field last so that action sits in the low bits
   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic [ChanWidth-1:0]  pwm_channel;
      logic [ByteWidth-1:0]  out_byte;
      action_type            action;
   } result_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= Ch0) && (b <= Ch9);
   endfunction

   // acc * 10 + digit, wrapping at 16 bits
   function automatic logic [ValueWidth-1:0] mac10(input logic [ValueWidth-1:0] acc,
                                                    input logic [7:0]            b);
      logic [7:0]            d8;
      logic [ValueWidth-1:0] d;
      d8 = b - Ch0;
      d  = {{(ValueWidth-4){1'b0}}, d8[3:0]};
      return (acc << 3) + (acc << 1) + d;
   endfunction

endpackage

// ===== rtl/scd_decode.sv =====
// scd_decode: decoder state registers and the per-byte decode logic
// depends on scd_pkg
`timescale 1ns / 1ps

module scd_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [scd_pkg::ByteWidth-1:0] rx_byte,
   input  logic [scd_pkg::ValueWidth-1:0] relay_pulse_ms,
   output scd_pkg::result_type           result
);
   import scd_pkg::*;

   state_type state_ff;
   state_type state_in;
   state_type cleared;
   logic [7:0] chan_off;

   always_comb begin
      cleared            = state_ff;
      cleared.in_msg     = 1'b0;
      cleared.kind       = KIND_NONE;
      cleared.width_acc  = '0;
      cleared.period_acc = '0;
      cleared.chan       = '0;
      chan_off           = rx_byte - ChA + 8'd1;
   end

   always_comb begin
      state_in           = state_ff;
      result.action      = ACT_NONE;
      result.out_byte    = rx_byte;
      result.pwm_channel = '0;
      result.value       = '0;
      if (!state_ff.cmd_mode) begin
         if (rx_byte == ChSlash) begin
            state_in.cmd_mode = 1'b1;
         end else begin
            result.action = ACT_PASS;
         end
      end else if (state_ff.in_msg) begin
         if (rx_byte == ChRbrace) begin
            case (state_ff.kind)
               KIND_PWM: begin
                  result.action      = ACT_SET_PWM;
                  result.pwm_channel = state_ff.chan;
                  result.value       = state_ff.width_acc;
               end
               KIND_PERIOD: begin
                  result.action = ACT_SET_PERIOD;
                  result.value  = state_ff.period_acc;
               end
               KIND_ACCEL: begin
                  result.action = ACT_ACCEL;
               end
               default: begin
                  result.action = ACT_EMPTY_CLOSE;
               end
            endcase
            state_in = cleared;
         end else if (state_ff.kind != KIND_NONE) begin
            result.action = ACT_MSG_ECHO;
            case (state_ff.kind)
               KIND_PWM: begin
                  if (state_ff.chan == '0) begin
                     if (rx_byte >= ChA && rx_byte <= ChD) begin
                        state_in.chan = chan_off[ChanWidth-1:0];
                     end else begin
                        result.action = ACT_MSG_ABORT;
                        state_in      = cleared;
                     end
                  end else if (is_digit(rx_byte)) begin
                     state_in.width_acc = mac10(state_ff.width_acc, rx_byte);
                  end else begin
                     result.action = ACT_MSG_ABORT;
                     state_in      = cleared;
                  end
               end
               KIND_PERIOD: begin
                  if (is_digit(rx_byte)) begin
                     state_in.period_acc = mac10(state_ff.period_acc, rx_byte);
                  end else begin
                     result.action = ACT_MSG_ABORT;
                     state_in      = cleared;
                  end
               end
               default: begin
               end
            endcase
         end else begin
            result.action = ACT_MSG_ECHO;
            if (rx_byte == ChP) begin
               state_in.kind = KIND_PWM;
            end else if (rx_byte == ChF) begin
               state_in.kind = KIND_PERIOD;
            end else if (rx_byte == ChA) begin
               state_in.kind = KIND_ACCEL;
            end
         end
      end else begin
         case (rx_byte)
            ChSlash:  result.action = ACT_ECHO_SLASH;
            ChM:      result.action = ACT_RADIO_MODE;
            ChN:      result.action = ACT_RADIO_TOG;
            ChR:      result.action = ACT_RADIO_REG;
            ChS:      result.action = ACT_TX_BUF;
            ChU:      result.action = ACT_TX_ADDR;
            ChT: begin
               result.action = ACT_RELAY_PULSE;
               result.value  = relay_pulse_ms;
            end
            Ch0:      result.action = ACT_RELAY_A_OFF;
            Ch1:      result.action = ACT_RELAY_A_ON;
            Ch2:      result.action = ACT_RELAY_B_OFF;
            Ch3:      result.action = ACT_RELAY_B_ON;
            ChLbrace: begin
               result.action   = ACT_MSG_OPEN;
               state_in.in_msg = 1'b1;
            end
            ChDot:    state_in.cmd_mode = 1'b0;
            default:  result.action = ACT_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.cmd_mode   <= 1'b1;
         state_ff.in_msg     <= 1'b0;
         state_ff.kind       <= KIND_NONE;
         state_ff.width_acc  <= '0;
         state_ff.period_acc <= '0;
         state_ff.chan       <= '0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/serial_command_decoder.sv =====
// serial_command_decoder: top level with input register, decoder core and result register
// depends on scd_pkg and scd_decode
`timescale 1ns / 1ps

// Decodes a stream of received serial bytes into action codes, one result per byte.
// A byte is taken into an input register, decoded by scd_decode and written to the result
// register once that register is free. One request is taken every cycle; the rate is set
// only by how fast rsp_tready drains the result register. The relay pulse duration is
// written through the csr_ channel, which is always ready; the user must write it only
// while no request is in flight, as the block itself does not enforce this.

module serial_command_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] rx_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,   // [4:0] action, [12:5] out_byte,
                                                       // [15:13] pwm_channel, [31:16] value
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [scd_pkg::ValueWidth-1:0] csr_data     // relay_pulse_ms
);
   import scd_pkg::*;

   logic                  in_valid_ff;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_data_ff;
   logic [ValueWidth-1:0] relay_pulse_ff;
   logic                  advance;
   result_type            result;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   scd_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .rx_byte        (in_byte_ff),
      .relay_pulse_ms (relay_pulse_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         relay_pulse_ff <= RelayPulseReset;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            relay_pulse_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

endmodule

// ===== rtl/scd_checker.sv =====
// scd_checker: port-level checks on the result channel of serial_command_decoder
// bound to the top level below; depends on scd_pkg
`timescale 1ns / 1ps

module scd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   import scd_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // action code in range
   a_action_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:0] <= ACT_EMPTY_CLOSE)
      else $error("action code out of range");

   // channel only with set pwm
   a_chan_only_pwm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4:0] != ACT_SET_PWM |-> rsp_tdata[15:13] == 3'd0)
      else $error("pwm channel on non-pwm action");

   // value only with relay pulse, pwm or period
   a_value_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4:0] != ACT_RELAY_PULSE && rsp_tdata[4:0] != ACT_SET_PWM
         && rsp_tdata[4:0] != ACT_SET_PERIOD |-> rsp_tdata[31:16] == 16'd0)
      else $error("value on action without value");

endmodule

bind serial_command_decoder scd_checker u_scd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/serial_command_decoder_tb.sv =====
// serial_command_decoder_tb: self-checking testbench for the serial command decoder
// streams bytes through req_, checks every rsp_ result against a local decoder model
// depends on scd_pkg and serial_command_decoder
`timescale 1ns / 1ps

module serial_command_decoder_tb;
   import scd_pkg::*;

   localparam int unsigned StallLimit  = 4000;
   localparam int unsigned HoldCycles  = 300;
   localparam int unsigned PhaseItems  = 190;
   localparam int unsigned ReportLimit = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = 16'h0000;

   // decoder model state
   logic                  mdl_command;
   logic                  mdl_in_msg;
   kind_type              mdl_kind;
   logic [ValueWidth-1:0] mdl_width;
   logic [ValueWidth-1:0] mdl_period;
   logic [ChanWidth-1:0]  mdl_chan;
   logic [ValueWidth-1:0] mdl_pulse_ms;

   logic [7:0] pending_bytes[$];
   result_type expected_results[$];

   int unsigned error_count = 0;
   int unsigned stall_cycles = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;
   int unsigned hold_left = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   bit          steady_req = 1'b0;
   bit          steady_rsp = 1'b0;
   bit          req_taken = 1'b0;

   serial_command_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void clear_message();
      mdl_in_msg = 1'b0;
      mdl_kind   = KIND_NONE;
      mdl_width  = '0;
      mdl_period = '0;
      mdl_chan   = '0;
   endfunction

   function automatic result_type decode_byte(input logic [7:0] b);
      result_type r;
      logic       digit;
      logic       abort;
      logic [7:0] chan8;
      r.action      = ACT_NONE;
      r.out_byte    = b;
      r.pwm_channel = '0;
      r.value       = '0;
      digit = (b >= Ch0) && (b <= Ch9);
      abort = 1'b0;
      if (!mdl_command) begin
         if (b == ChSlash) mdl_command = 1'b1;
         else r.action = ACT_PASS;
      end else if (mdl_in_msg) begin
         if (b == ChRbrace) begin
            case (mdl_kind)
               KIND_PWM: begin
                  r.action      = ACT_SET_PWM;
                  r.pwm_channel = mdl_chan;
                  r.value       = mdl_width;
               end
               KIND_PERIOD: begin
                  r.action = ACT_SET_PERIOD;
                  r.value  = mdl_period;
               end
               KIND_ACCEL: r.action = ACT_ACCEL;
               default:    r.action = ACT_EMPTY_CLOSE;
            endcase
            clear_message();
         end else if (mdl_kind != KIND_NONE) begin
            if (mdl_kind == KIND_PWM) begin
               if (mdl_chan == 0) begin
                  if (b < ChA || b > ChD) begin
                     abort = 1'b1;
                  end else begin
                     chan8    = b - ChA + 8'd1;
                     mdl_chan = chan8[ChanWidth-1:0];
                  end
               end else if (!digit) begin
                  abort = 1'b1;
               end else begin
                  mdl_width = mdl_width * 16'd10 + {8'd0, b - Ch0};
               end
            end else if (mdl_kind == KIND_PERIOD) begin
               if (!digit) abort = 1'b1;
               else mdl_period = mdl_period * 16'd10 + {8'd0, b - Ch0};
            end
            if (abort) begin
               clear_message();
               r.action = ACT_MSG_ABORT;
            end else begin
               r.action = ACT_MSG_ECHO;
            end
         end else begin
            if (b == ChP) mdl_kind = KIND_PWM;
            else if (b == ChF) mdl_kind = KIND_PERIOD;
            else if (b == ChA) mdl_kind = KIND_ACCEL;
            r.action = ACT_MSG_ECHO;
         end
      end else begin
         case (b)
            ChSlash: r.action = ACT_ECHO_SLASH;
            ChM:     r.action = ACT_RADIO_MODE;
            ChN:     r.action = ACT_RADIO_TOG;
            ChR:     r.action = ACT_RADIO_REG;
            ChS:     r.action = ACT_TX_BUF;
            ChU:     r.action = ACT_TX_ADDR;
            ChT: begin
               r.action = ACT_RELAY_PULSE;
               r.value  = mdl_pulse_ms;
            end
            Ch0:     r.action = ACT_RELAY_A_OFF;
            Ch1:     r.action = ACT_RELAY_A_ON;
            Ch2:     r.action = ACT_RELAY_B_OFF;
            Ch3:     r.action = ACT_RELAY_B_ON;
            ChLbrace: begin
               mdl_in_msg = 1'b1;
               r.action   = ACT_MSG_OPEN;
            end
            ChDot:   mdl_command = 1'b0;
            default: r.action = ACT_NONE;
         endcase
      end
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(40, 150);
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= ReportLimit)
            $display("mismatch in %s: expected %0d, got %0d", name, want, got);
      end
   endtask

   task automatic push_digits(input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         pending_bytes.push_back(Ch0 + 8'($urandom_range(0, 9)));
   endtask

   task automatic push_noise(input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         pending_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // a non-digit byte, for breaking a run of digits
   function automatic logic [7:0] pick_non_digit();
      logic [7:0] v;
      v = 8'($urandom_range(0, 255));
      if (v >= Ch0 && v <= Ch9) v = v + 8'd20;
      return v;
   endfunction

   task automatic push_number();
      int unsigned n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
      push_digits(n);
      if ($urandom_range(0, 9) == 0) begin
         pending_bytes.push_back(pick_non_digit());
         push_digits($urandom_range(0, 2));
      end
   endtask

   task automatic push_sequence();
      logic [7:0]  cmd_list [12];
      logic [7:0]  junk;
      int unsigned pick;
      int unsigned r;
      cmd_list = '{ChM, ChN, ChR, ChS, ChU, ChT, Ch0, Ch1, Ch2, Ch3, ChSlash, ChLbrace};
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         pending_bytes.push_back(cmd_list[$urandom_range(0, 10)]);
      end else if (pick < 25) begin
         push_noise($urandom_range(1, 4));
      end else if (pick < 35) begin
         pending_bytes.push_back(ChDot);
         push_noise($urandom_range(1, 6));
         pending_bytes.push_back(ChSlash);
      end else if (pick < 58) begin
         pending_bytes.push_back(ChLbrace);
         if ($urandom_range(0, 3) == 0) begin
            junk = 8'($urandom_range(0, 255));
            if (junk == ChP || junk == ChF || junk == ChA || junk == ChRbrace) junk = 8'h21;
            pending_bytes.push_back(junk);
         end
         pending_bytes.push_back(ChP);
         r = $urandom_range(0, 99);
         if (r < 85) pending_bytes.push_back(ChA + 8'($urandom_range(0, 3)));
         else if (r < 93) push_noise(1);
         if (r < 93) push_number();
         pending_bytes.push_back(ChRbrace);
      end else if (pick < 75) begin
         pending_bytes.push_back(ChLbrace);
         pending_bytes.push_back(ChF);
         push_number();
         pending_bytes.push_back(ChRbrace);
      end else if (pick < 85) begin
         pending_bytes.push_back(ChLbrace);
         pending_bytes.push_back(ChA);
         push_noise($urandom_range(0, 3));
         pending_bytes.push_back(ChRbrace);
      end else if (pick < 92) begin
         pending_bytes.push_back(ChLbrace);
         push_noise($urandom_range(0, 2));
         pending_bytes.push_back(ChRbrace);
      end else begin
         pending_bytes.push_back(cmd_list[$urandom_range(0, 11)]);
         push_noise($urandom_range(1, 3));
      end
   endtask

   task automatic fill_random(input int unsigned count);
      int unsigned target;
      target = pending_bytes.size() + count;
      while (pending_bytes.size() < target) push_sequence();
   endtask

   task automatic wait_idle();
      while (pending_bytes.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_pulse_ms(input logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mdl_pulse_ms = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_tdata  <= pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_gap = steady_req ? 0 : pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // request acceptance and prediction
   always @(posedge clock) begin
      req_taken = req_tvalid && req_tready;
      if (req_taken) expected_results.push_back(decode_byte(req_tdata));
   end

   // response receiver, with random stalls and the occasional long hold
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall = rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = steady_rsp ? 0 : pick_gap();
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      result_type got;
      result_type want;
      if (rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata);
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= ReportLimit)
               $display("response with nothing outstanding: %h", rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            check_field("action", want.action, got.action);
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("pwm_channel", want.pwm_channel, got.pwm_channel);
            check_field("value", want.value, got.value);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
         if (stall_cycles >= StallLimit) begin
            $display("serial_command_decoder_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0] settings [5];
      settings = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom_range(2, 65534)), 16'h8000};
      mdl_command  = 1'b1;
      mdl_pulse_ms = RelayPulseReset;
      clear_message();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every command, echo before a kind, bad channel, period overflow,
      // empty close, pass-through with extremes, slash echo, unknown byte
      pending_bytes = '{ChM, ChN, ChR, ChS, ChU, ChT, Ch0, Ch1, Ch2, Ch3,
                        ChLbrace, 8'h71, ChP, 8'h65,
                        ChLbrace, ChF, Ch9, Ch9, Ch9, Ch9, Ch9, ChRbrace,
                        ChLbrace, ChRbrace,
                        ChDot, 8'hFF, 8'h00, ChSlash,
                        ChSlash, 8'h80};
      fill_random(PhaseItems - 30);
      wait_idle();

      for (int k = 0; k < 5; k++) begin
         write_pulse_ms(settings[k]);
         steady_req = (k == 2);
         steady_rsp = (k == 2);
         fill_random(PhaseItems);
         if (k == 1) hold_requests++;
         wait_idle();
      end

      repeat (10) @(posedge clock);
      error_count += expected_results.size();
      if (error_count == 0)
         $display("serial_command_decoder_tb: clean");
      else
         $display("serial_command_decoder_tb: errors");
      $finish;
   end

endmodule
